### rtl/core/unique_id_set_table_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the unique id set table
// Clocked property shorthands shared by the RTL that carries checks.
// ----------------------------------------------------------------------------
`ifndef UNIQUE_ID_SET_TABLE_ASSERT_SVH
`define UNIQUE_ID_SET_TABLE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define UIST_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define UIST_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/uist_pkg.sv
// ----------------------------------------------------------------------------
// uist_pkg
// Shared widths, command codes and defaults for the unique id set table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package uist_pkg;

   localparam int CAPACITY_DEF = 64;

   localparam int CMD_W   = 2;
   localparam int ID_W    = 32;
   localparam int INDEX_W = 6;
   localparam int COUNT_W = 7;

   typedef enum logic [CMD_W-1:0] {
      CMD_ADD    = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_TEST   = 2'd2,
      CMD_READ   = 2'd3
   } cmd_type;

endpackage

### rtl/core/uist_ifs.sv
// ----------------------------------------------------------------------------
// uist channel interfaces
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface uist_req_if
   import uist_pkg::*;
   ;
   logic               valid;
   logic               ready;
   logic [CMD_W-1:0]   command;
   logic [ID_W-1:0]    item_id;
   logic [INDEX_W-1:0] entry_index;

   modport source (output valid, output command, output item_id,
                   output entry_index, input ready);
   modport sink   (input valid, input command, input item_id,
                   input entry_index, output ready);
endinterface

interface uist_rsp_if
   import uist_pkg::*;
   ;
   logic               valid;
   logic               ready;
   logic               success;
   logic [ID_W-1:0]    item_value;
   logic [COUNT_W-1:0] entry_count;

   modport source (output valid, output success, output item_value,
                   output entry_count, input ready);
   modport sink   (input valid, input success, input item_value,
                   input entry_count, output ready);
endinterface

### rtl/core/unique_id_set_table.sv
// ----------------------------------------------------------------------------
// unique_id_set_table
// Bounded, insertion-ordered set of unique 32-bit ids with search and
// compaction walked over a table memory with one read port and one write port.
// ----------------------------------------------------------------------------
// Command items (add, remove, test, read at index) are taken one at a time;
// req_if.ready is high only while the sequencer is idle, but a finished result
// may still be waiting on rsp_if, so the next item can be taken before the
// previous result is collected. Every item yields exactly one result item with
// a success flag, a value (the entry for a successful read, zero otherwise)
// and the count after the command, saturated at 127. All table traffic goes
// through one memory read port and one write port with registered read data,
// and the compare runs one entry per cycle behind the read. The walk of an add
// or test stops early on a hit, an add to a full table fails without walking,
// and a remove that hits goes on with a shift pass that picks up right after
// the matching entry and moves each later entry down one place.
// The table starts empty after reset; no clearing pass is needed because
// only positions below the count are ever read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module unique_id_set_table
   import uist_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic       clock,
   input  logic       reset,
   uist_req_if.sink   req_if,
   uist_rsp_if.source rsp_if
);

   // Address bits of the table, count bits (must hold CAPACITY itself) and a
   // compare width wide enough for the count, the index field and 127.
   localparam int AW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW  = $clog2(CAPACITY + 1);
   localparam int XW0 = (CW > INDEX_W) ? CW : INDEX_W;
   localparam int XW  = (XW0 > COUNT_W) ? XW0 : COUNT_W;
   localparam logic [XW-1:0] COUNT_SAT = XW'((1 << COUNT_W) - 1);

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_SEARCH = 5'b00010,
      S_SHIFT  = 5'b00100,
      S_READ   = 5'b01000,
      S_DONE   = 5'b10000
   } state_type;

   // Sequencer and working registers
   state_type        state_ff, state_in;
   cmd_type          cmd_ff, cmd_in;
   logic [ID_W-1:0]  id_ff, id_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [CW-1:0]    scan_ff, scan_in;   // next position to read
   logic [CW-1:0]    pos_ff, pos_in;     // position whose data sits in rd_data_ff
   logic             pend_ff, pend_in;   // rd_data_ff holds a fresh read
   logic             ok_ff, ok_in;
   logic [ID_W-1:0]  value_ff, value_in;

   // Result output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_ok_ff, rsp_ok_in;
   logic [ID_W-1:0]    rsp_value_ff, rsp_value_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   // Table memory ports
   logic [ID_W-1:0] entry_mem [CAPACITY];
   logic            rd_en;
   logic [AW-1:0]   rd_addr;
   logic [ID_W-1:0] rd_data_ff;
   logic            wr_en;
   logic [AW-1:0]   wr_addr;
   logic [ID_W-1:0] wr_data;

   logic          accept;
   logic          issue;
   logic          hit;
   logic [CW-1:0] pos_dec;
   logic [CW-1:0] pos_inc;
   logic [XW-1:0] index_ext;
   logic [XW-1:0] count_ext;

   assign req_if.ready = (state_ff == S_IDLE);
   assign accept       = req_if.valid && req_if.ready;

   assign issue     = (scan_ff < count_ff);
   assign hit       = pend_ff && (rd_data_ff == id_ff);
   assign pos_dec   = pos_ff - CW'(1);
   assign pos_inc   = pos_ff + CW'(1);
   assign index_ext = XW'(req_if.entry_index);
   assign count_ext = XW'(count_ff);

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      id_in        = id_ff;
      count_in     = count_ff;
      scan_in      = scan_ff;
      pos_in       = pos_ff;
      pend_in      = 1'b0;
      ok_in        = ok_ff;
      value_in     = value_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_ok_in    = rsp_ok_ff;
      rsp_value_in = rsp_value_ff;
      rsp_count_in = rsp_count_ff;
      rd_en        = 1'b0;
      rd_addr      = scan_ff[AW-1:0];
      wr_en        = 1'b0;
      wr_addr      = count_ff[AW-1:0];
      wr_data      = id_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd_in   = cmd_type'(req_if.command);
               id_in    = req_if.item_id;
               scan_in  = '0;
               ok_in    = 1'b0;
               value_in = '0;
               unique case (cmd_type'(req_if.command))
                  CMD_READ: begin
                     // Issue the read now; data lands next cycle.
                     if (index_ext < count_ext) begin
                        rd_en    = 1'b1;
                        rd_addr  = AW'(req_if.entry_index);
                        state_in = S_READ;
                     end else begin
                        state_in = S_DONE;
                     end
                  end
                  CMD_ADD: begin
                     // Full table: fail without walking.
                     if (count_ff == CW'(CAPACITY)) begin
                        state_in = S_DONE;
                     end else begin
                        state_in = S_SEARCH;
                     end
                  end
                  default: begin
                     state_in = S_SEARCH;
                  end
               endcase
            end
         end

         S_SEARCH: begin
            if (hit) begin
               // Match at pos_ff: add fails, test succeeds, remove compacts.
               case (cmd_ff)
                  CMD_REMOVE: begin
                     scan_in  = pos_inc;
                     state_in = S_SHIFT;
                  end
                  CMD_TEST: begin
                     ok_in    = 1'b1;
                     state_in = S_DONE;
                  end
                  default: begin
                     ok_in    = 1'b0;
                     state_in = S_DONE;
                  end
               endcase
            end else if (!issue && !pend_ff) begin
               // Walk finished with no match: append on add.
               if (cmd_ff == CMD_ADD) begin
                  wr_en    = 1'b1;
                  count_in = count_ff + CW'(1);
                  ok_in    = 1'b1;
               end else begin
                  ok_in    = 1'b0;
               end
               state_in = S_DONE;
            end else if (issue) begin
               rd_en   = 1'b1;
               pos_in  = scan_ff;
               scan_in = scan_ff + CW'(1);
               pend_in = 1'b1;
            end
         end

         S_SHIFT: begin
            // Move the entry read last cycle down one place.
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = pos_dec[AW-1:0];
               wr_data = rd_data_ff;
            end
            if (issue) begin
               rd_en   = 1'b1;
               pos_in  = scan_ff;
               scan_in = scan_ff + CW'(1);
               pend_in = 1'b1;
            end else if (!pend_ff) begin
               count_in = count_ff - CW'(1);
               ok_in    = 1'b1;
               state_in = S_DONE;
            end
         end

         S_READ: begin
            ok_in    = 1'b1;
            value_in = rd_data_ff;
            state_in = S_DONE;
         end

         S_DONE: begin
            // Hand the result to the output register once it is free.
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = ok_ff;
               rsp_value_in = value_ff;
               rsp_count_in = (count_ext > COUNT_SAT) ? COUNT_SAT[COUNT_W-1:0]
                                                      : count_ext[COUNT_W-1:0];
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      id_ff        <= id_in;
      scan_ff      <= scan_in;
      pos_ff       <= pos_in;
      ok_ff        <= ok_in;
      value_ff     <= value_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_value_ff <= rsp_value_in;
      rsp_count_ff <= rsp_count_in;
   end

   // Table memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= entry_mem[rd_addr];
      end
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.success     = rsp_ok_ff;
   assign rsp_if.item_value  = rsp_value_ff;
   assign rsp_if.entry_count = rsp_count_ff;

   // ------------------------------------------------------------------------
   // Checks
   // ------------------------------------------------------------------------
`include "unique_id_set_table_assert.svh"

   // Count never passes the table size.
   `UIST_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(CAPACITY), "count above capacity")
   // Count holds while the sequencer idles without a new item.
   `UIST_ASSERT_NEXT(a_idle_count, clock, reset, (state_ff == S_IDLE) && !accept, $stable(count_ff), "count moved while idle")
   // Compaction only runs on a non-empty table and writes below the count.
   `UIST_ASSERT_NOW(a_shift_write, clock, reset, (state_ff == S_SHIFT) && wr_en, (count_ff != '0) && (CW'(wr_addr) < count_ff), "shift write outside table")
   // A result is loaded only when leaving the done state.
   `UIST_ASSERT_NEXT(a_done_load, clock, reset, (state_ff == S_DONE) && (!rsp_valid_ff || rsp_if.ready), rsp_valid_ff && (state_ff == S_IDLE), "result not loaded")

endmodule

### sim/unique_id_set_table_tb.sv
// ----------------------------------------------------------------------------
// unique_id_set_table_tb
// Self-checking bench for the bounded unique id set table. A queue of
// commands feeds a clocked driver. A shadow copy of the table predicts every
// result, and a clocked monitor checks each result item against the oldest
// prediction while both channel sides idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module unique_id_set_table_tb;
   import uist_pkg::*;

   localparam int LIMIT_CYCLES = 1_000_000;
   localparam int SETTLE_CYCLES = 200;     // above the slowest remove
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int LONG_HOLD_AT = 250;      // accepted items before the long hold
   localparam int CALM_TAIL_ITEMS = 60;    // last items run without idling
   localparam int MAX_REPORTS = 10;

   // One queued entry: a command item, or a marker that pauses the sender
   // until every outstanding result has come back.
   typedef struct {
      logic               drain_marker;
      cmd_type            command;
      logic [ID_W-1:0]    item_id;
      logic [INDEX_W-1:0] entry_index;
   } table_command_type;

   typedef struct packed {
      logic               success;
      logic [ID_W-1:0]    item_value;
      logic [COUNT_W-1:0] entry_count;
   } table_reply_type;

   logic clock;
   logic reset;

   uist_req_if req_ch ();
   uist_rsp_if rsp_ch ();

   unique_id_set_table #(
      .CAPACITY (CAPACITY_DEF)
   ) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   // Shadow of the table contents and fill level.
   logic [ID_W-1:0] shadow_ids [CAPACITY_DEF];
   int              shadow_count;

   table_command_type pending_commands [$];
   table_reply_type   expected_replies [$];
   logic [ID_W-1:0]   id_pool [$];

   int  items_accepted;
   int  replies_seen;
   int  mismatch_count;
   int  cycle_count;
   int  send_gap;
   int  stall_left;
   int  hold_left;
   bit  hold_done;
   bit  waiting_drain;

   always #2 clock = ~clock;

   // Apply one command to the shadow table and return the result it owes.
   function automatic table_reply_type apply_table_command(input cmd_type op,
                                                           input logic [ID_W-1:0] id,
                                                           input logic [INDEX_W-1:0] idx);
      table_reply_type reply;
      int              hit;
      reply = '0;
      hit = -1;
      // Search stops at the first match, as the block's walk does.
      for (int i = 0; i < shadow_count; i++) begin
         if (hit < 0 && shadow_ids[i] == id) hit = i;
      end
      case (op)
         CMD_ADD: begin
            if (shadow_count < CAPACITY_DEF && hit < 0) begin
               shadow_ids[shadow_count] = id;
               shadow_count++;
               reply.success = 1'b1;
            end
         end
         CMD_REMOVE: begin
            // Close the gap: shift every later entry down one place.
            if (hit >= 0) begin
               for (int j = hit; j < shadow_count - 1; j++) shadow_ids[j] = shadow_ids[j + 1];
               shadow_count--;
               reply.success = 1'b1;
            end
         end
         CMD_TEST: begin
            reply.success = (hit >= 0);
         end
         default: begin
            if (int'(idx) < shadow_count) begin
               reply.item_value = shadow_ids[idx];
               reply.success = 1'b1;
            end
         end
      endcase
      reply.entry_count = (shadow_count > 127) ? COUNT_W'(127) : COUNT_W'(shadow_count);
      return reply;
   endfunction

   // Idling runs in stretches: two blocks of 48 items on, one off, and
   // nothing at all in the calm tail of the run.
   function automatic bit idling_on();
      return pending_commands.size() >= CALM_TAIL_ITEMS && (items_accepted / 48) % 3 != 1;
   endfunction

   task automatic queue_command(input cmd_type op, input logic [ID_W-1:0] id,
                                input logic [INDEX_W-1:0] idx);
      table_command_type c;
      c.drain_marker = 1'b0;
      c.command = op;
      c.item_id = id;
      c.entry_index = idx;
      pending_commands.push_back(c);
   endtask

   task automatic queue_drain();
      table_command_type c;
      c.drain_marker = 1'b1;
      c.command = CMD_TEST;
      c.item_id = '0;
      c.entry_index = '0;
      pending_commands.push_back(c);
   endtask

   // Pick an id: mostly one seen before so hits happen, otherwise fresh.
   function automatic logic [ID_W-1:0] pick_id();
      logic [ID_W-1:0] id;
      if (id_pool.size() > 0 && $urandom_range(9) < 7) begin
         id = id_pool[$urandom_range(id_pool.size() - 1)];
      end else begin
         id = $urandom;
         id_pool.push_back(id);
      end
      return id;
   endfunction

   // Build a mixed stretch of well-formed commands with random content.
   task automatic queue_mixed(input int n);
      int w;
      for (int k = 0; k < n; k++) begin
         w = $urandom_range(99);
         if (w < 35) begin
            queue_command(CMD_ADD, pick_id(), INDEX_W'($urandom));
         end else if (w < 60) begin
            queue_command(CMD_REMOVE, pick_id(), INDEX_W'($urandom));
         end else if (w < 80) begin
            queue_command(CMD_TEST, pick_id(), INDEX_W'($urandom));
         end else if (w < 90) begin
            queue_command(CMD_READ, $urandom, INDEX_W'($urandom_range(63)));
         end else begin
            queue_command(CMD_READ, $urandom, INDEX_W'($urandom_range(15)));
         end
      end
   endtask

   // Driver: record the prediction on each accepted item, then advance to
   // the next queued command once the current one is gone.
   always @(posedge clock) begin : drive_commands
      table_command_type c;
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_ch.command <= CMD_ADD;
         req_ch.item_id <= '0;
         req_ch.entry_index <= '0;
         send_gap = 0;
         waiting_drain = 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            expected_replies.push_back(apply_table_command(cmd_type'(req_ch.command),
                                                           req_ch.item_id,
                                                           req_ch.entry_index));
            items_accepted++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (waiting_drain && expected_replies.size() == 0) waiting_drain = 1'b0;
            if (waiting_drain) begin
               req_ch.valid <= 1'b0;
            end else if (send_gap > 0) begin
               send_gap--;
               req_ch.valid <= 1'b0;
            end else if (pending_commands.size() == 0) begin
               req_ch.valid <= 1'b0;
            end else begin
               c = pending_commands.pop_front();
               if (c.drain_marker) begin
                  // Hold off the sender until every result is back.
                  waiting_drain = 1'b1;
                  req_ch.valid <= 1'b0;
               end else begin
                  req_ch.valid <= 1'b1;
                  req_ch.command <= c.command;
                  req_ch.item_id <= c.item_id;
                  req_ch.entry_index <= c.entry_index;
                  if (idling_on() && $urandom_range(3) == 0) send_gap = $urandom_range(1, 3);
               end
            end
         end
      end
   end

   // Monitor: check each accepted result against the oldest prediction.
   always @(posedge clock) begin : check_replies
      table_reply_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         replies_seen++;
         if (expected_replies.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("result %0d with no command outstanding: success=%0d value=%h count=%0d",
                        replies_seen, rsp_ch.success, rsp_ch.item_value, rsp_ch.entry_count);
         end else begin
            want = expected_replies.pop_front();
            if (rsp_ch.success !== want.success || rsp_ch.item_value !== want.item_value ||
                rsp_ch.entry_count !== want.entry_count) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("result %0d: expected success=%0d value=%h count=%0d, got %0d %h %0d",
                           replies_seen, want.success, want.item_value, want.entry_count,
                           rsp_ch.success, rsp_ch.item_value, rsp_ch.entry_count);
            end
         end
      end
   end

   // Receiver ready: short random stalls, plus one long hold while the
   // sender keeps offering, so the block fills up and stalls its input.
   always @(posedge clock) begin : drive_ready
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         stall_left = 0;
         hold_left = 0;
         hold_done = 1'b0;
      end else begin
         if (!hold_done && items_accepted >= LONG_HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
            if (idling_on() && $urandom_range(3) == 0) stall_left = $urandom_range(1, 3);
         end
      end
   end

   // Watchdog: end the run if it hangs.
   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("unique_id_set_table: mismatch");
         $finish;
      end
   end

   initial begin : stimulus
      clock = 1'b0;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.command = CMD_ADD;
      req_ch.item_id = '0;
      req_ch.entry_index = '0;
      rsp_ch.ready = 1'b0;
      shadow_count = 0;
      items_accepted = 0;
      replies_seen = 0;
      mismatch_count = 0;
      cycle_count = 0;

      // Directed: field extremes, duplicates, absent ids, reads at and past
      // the count, compaction from the front and the middle, empty table.
      queue_command(CMD_ADD, 32'h0000_0000, 6'd63);
      queue_command(CMD_ADD, 32'hFFFF_FFFF, 6'd0);
      queue_command(CMD_ADD, 32'h0000_0000, 6'd21);   // duplicate
      queue_command(CMD_TEST, 32'h0000_0000, 6'd42);
      queue_command(CMD_TEST, 32'h1234_5678, 6'd0);   // absent
      queue_command(CMD_READ, 32'hFFFF_FFFF, 6'd0);
      queue_command(CMD_READ, 32'h0000_0000, 6'd1);
      queue_command(CMD_READ, 32'hDEAD_BEEF, 6'd2);   // at the count
      queue_command(CMD_READ, 32'h0000_0000, 6'd63);  // far past the count
      queue_command(CMD_REMOVE, 32'h8765_4321, 6'd0); // absent
      queue_command(CMD_REMOVE, 32'h0000_0000, 6'd63);// first entry, shift down
      queue_command(CMD_READ, 32'h0000_0000, 6'd0);
      queue_command(CMD_REMOVE, 32'hFFFF_FFFF, 6'd0);
      queue_command(CMD_READ, 32'hFFFF_FFFF, 6'd0);   // empty table
      queue_command(CMD_REMOVE, 32'hFFFF_FFFF, 6'd0); // remove on empty
      queue_command(CMD_TEST, 32'hFFFF_FFFF, 6'd63);  // test on empty
      queue_command(CMD_ADD, 32'hA5A5_A5A5, 6'd63);
      queue_command(CMD_ADD, 32'h5A5A_5A5A, 6'd0);
      queue_command(CMD_ADD, 32'h0000_0003, 6'd42);
      queue_command(CMD_REMOVE, 32'h5A5A_5A5A, 6'd21);// middle entry
      queue_command(CMD_READ, 32'h5A5A_5A5A, 6'd1);
      queue_command(CMD_TEST, 32'h5A5A_5A5A, 6'd0);
      queue_command(CMD_TEST, 32'h0000_0003, 6'd0);
      id_pool.push_back(32'h0000_0000);
      id_pool.push_back(32'hFFFF_FFFF);
      id_pool.push_back(32'hA5A5_A5A5);
      id_pool.push_back(32'h5A5A_5A5A);
      id_pool.push_back(32'h0000_0003);
      queue_drain();

      // Fill past capacity so adds to a full table occur, then re-add a
      // stored id and read the top slot.
      for (int k = 0; k < 70; k++) begin
         id_pool.push_back($urandom);
         queue_command(CMD_ADD, id_pool[id_pool.size() - 1], INDEX_W'($urandom));
      end
      queue_command(CMD_ADD, 32'hA5A5_A5A5, 6'd0);
      queue_command(CMD_READ, $urandom, 6'd63);
      queue_command(CMD_READ, $urandom, 6'd62);

      queue_mixed(130);
      queue_drain();
      queue_mixed(130);
      queue_mixed(130);

      // Drain toward empty with removes of mostly known ids.
      for (int k = 0; k < 50; k++) queue_command(CMD_REMOVE, pick_id(), INDEX_W'($urandom));
      queue_mixed(10);

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Wait for the sender to run dry and every result to come back.
      while (pending_commands.size() != 0 || req_ch.valid || waiting_drain ||
             expected_replies.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && expected_replies.size() == 0) begin
         $display("unique_id_set_table: match");
      end else begin
         $display("unique_id_set_table: mismatch");
      end
      $finish;
   end

endmodule
